// ===== rtl/hga_pkg.sv =====
// Shared constants, codes and types for the generational handle allocator.
`default_nettype none

package hga_pkg;

  // Slot table size and derived widths
  localparam int SLOT_COUNT  = 1024;
  localparam int IDX_W       = $clog2(SLOT_COUNT);
  localparam int CNT_W       = $clog2(SLOT_COUNT + 1);
  localparam int GEN_BITS    = 32;
  localparam int VER_W       = 32;
  localparam int OP_W        = 2;
  localparam int STATUS_W    = 2;
  localparam int IN_TDATA_W  = 48;
  localparam int OUT_TDATA_W = 48;

  // Request codes carried in tuser
  typedef enum logic [OP_W-1:0] {
    OP_SPAWN   = 2'd0,
    OP_DESPAWN = 2'd1,
    OP_QUERY   = 2'd2,
    OP_NOP     = 2'd3
  } opcode_t;

  // Result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_DEAD = 2'd2
  } status_t;

  // One slot of the table: live flag plus stored generation
  typedef struct packed {
    logic                live;
    logic [GEN_BITS-1:0] gen;
  } slot_entry_t;

  // Slot table write request
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    slot_entry_t      data;
  } slot_wr_t;

  // Free queue entry: freed slot and the generation it will be reused with
  typedef struct packed {
    logic [IDX_W-1:0]    slot;
    logic [GEN_BITS-1:0] gen;
  } queue_entry_t;

  // Free queue control from the datapath
  typedef struct packed {
    logic         push;
    logic         pop;
    queue_entry_t entry;
  } queue_ctl_t;

  // Free queue status to the datapath
  typedef struct packed {
    logic empty;
    logic full;
  } queue_stat_t;

endpackage

`default_nettype wire

// ===== rtl/hga_slot_store.sv =====
// Slot table memory: live flag and generation per slot, write-first read port.
`default_nettype none

module hga_slot_store (
  input  wire                        clk,
  input  wire                        rd_en,
  input  wire [hga_pkg::IDX_W-1:0]   rd_addr,
  input  wire hga_pkg::slot_wr_t     wr,
  output hga_pkg::slot_entry_t       rd_data
);

  hga_pkg::slot_entry_t mem [hga_pkg::SLOT_COUNT];
  hga_pkg::slot_entry_t rd_data_r;

  // Write the slot updated by the item leaving the datapath
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Read for the incoming item; forward a same-edge write to the same slot
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (wr.we && (wr.addr == rd_addr)) begin
        rd_data_r <= wr.data;
      end else begin
        rd_data_r <= mem[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

// ===== rtl/hga_free_queue.sv =====
// Circular FIFO of freed slots with a prefetched head entry.
`default_nettype none

module hga_free_queue (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire hga_pkg::queue_ctl_t ctl,
  output hga_pkg::queue_stat_t    stat,
  output hga_pkg::queue_entry_t   head_entry
);

  hga_pkg::queue_entry_t mem [hga_pkg::SLOT_COUNT];
  hga_pkg::queue_entry_t head_entry_r;

  logic [hga_pkg::IDX_W-1:0] head_r, head_nxt;
  logic [hga_pkg::IDX_W-1:0] tail_r, tail_nxt;
  logic [hga_pkg::CNT_W-1:0] count_r, count_nxt;

  localparam logic [hga_pkg::IDX_W-1:0] LAST_POS = hga_pkg::IDX_W'(hga_pkg::SLOT_COUNT - 1);

  // Advance pointers and occupancy
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    count_nxt = count_r;
    if (ctl.pop) begin
      head_nxt = (head_r == LAST_POS) ? '0 : head_r + 1'b1;
    end
    if (ctl.push) begin
      tail_nxt = (tail_r == LAST_POS) ? '0 : tail_r + 1'b1;
    end
    if (ctl.push && !ctl.pop) begin
      count_nxt = count_r + 1'b1;
    end else if (ctl.pop && !ctl.push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // Store pushed words
  always_ff @(posedge clk) begin
    if (ctl.push) begin
      mem[tail_r] <= ctl.entry;
    end
  end

  // Prefetch the next head word; forward a push landing at that position
  always_ff @(posedge clk) begin
    if (ctl.push && (tail_r == head_nxt)) begin
      head_entry_r <= ctl.entry;
    end else begin
      head_entry_r <= mem[head_nxt];
    end
  end

  assign head_entry = head_entry_r;
  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == hga_pkg::CNT_W'(hga_pkg::SLOT_COUNT));

endmodule

`default_nettype wire

// ===== rtl/generational_handle_allocator.sv =====
// A word accepted on in_ passes the stage register and then the output register to the out_ port.
// Throughput: one word per cycle unless out_tready stalls; the slot table read is registered
// at input accept and the update is written back as the word moves to the output register.
// Reset (rst_n low, synchronous) empties the pipeline, the free queue and the
// high-water mark; the slot and queue memories are not cleared and need no sweep.
`default_nettype none

module generational_handle_allocator (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 in_tvalid,
  output logic                                in_tready,
  input  wire [hga_pkg::IN_TDATA_W-1:0]       in_tdata,   // entity_index[9:0], entity_version[41:10]
  input  wire [hga_pkg::OP_W-1:0]             in_tuser,   // opcode[1:0]
  output logic                                out_tvalid,
  input  wire                                 out_tready,
  // out_tdata: handle_index[9:0], handle_version[41:10], handle_live[42]
  output logic [hga_pkg::OUT_TDATA_W-1:0]     out_tdata,
  output logic [hga_pkg::STATUS_W-1:0]        out_tuser   // status[1:0]
);

  // Stage registers
  logic                          s1_valid_r;
  hga_pkg::opcode_t              s1_op_r;
  logic [hga_pkg::IDX_W-1:0]     s1_idx_r;
  logic [hga_pkg::VER_W-1:0]     s1_ver_r;
  logic [hga_pkg::CNT_W-1:0]     high_water_r, high_water_nxt;

  logic                          out_valid_r;
  hga_pkg::status_t              out_status_r, out_status_nxt;
  logic [hga_pkg::IDX_W-1:0]     out_idx_r, out_idx_nxt;
  logic [hga_pkg::VER_W-1:0]     out_ver_r, out_ver_nxt;
  logic                          out_live_r, out_live_nxt;

  logic                          in_accept;
  logic                          s1_adv;

  hga_pkg::slot_wr_t             slot_wr;
  hga_pkg::slot_entry_t          slot_rd;
  hga_pkg::queue_ctl_t           q_ctl;
  hga_pkg::queue_stat_t          q_stat;
  hga_pkg::queue_entry_t         q_head;

  logic                          in_range;
  logic [hga_pkg::GEN_BITS-1:0]  gen_bump;

  // Handshake
  assign s1_adv    = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s1_adv;
  assign in_accept = in_tvalid && in_tready;

  // Slot table and free queue
  hga_slot_store u_slot_store (
    .clk     (clk),
    .rd_en   (in_accept),
    .rd_addr (in_tdata[hga_pkg::IDX_W-1:0]),
    .wr      (slot_wr),
    .rd_data (slot_rd)
  );

  hga_free_queue u_free_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (q_ctl),
    .stat       (q_stat),
    .head_entry (q_head)
  );

  // Capture the incoming word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_op_r  <= hga_pkg::opcode_t'(in_tuser);
      s1_idx_r <= in_tdata[hga_pkg::IDX_W-1:0];
      s1_ver_r <= in_tdata[hga_pkg::IDX_W +: hga_pkg::VER_W];
    end
  end

  assign in_range = (hga_pkg::CNT_W'(s1_idx_r) < high_water_r);
  assign gen_bump = slot_rd.gen + 1'b1;

  // Decode the operation and build state updates
  always_comb begin
    slot_wr        = '0;
    q_ctl          = '0;
    high_water_nxt = high_water_r;
    out_status_nxt = hga_pkg::ST_OK;
    out_idx_nxt    = '0;
    out_ver_nxt    = '0;
    out_live_nxt   = 1'b0;
    case (s1_op_r)
      hga_pkg::OP_SPAWN: begin
        if (!q_stat.empty) begin
          q_ctl.pop          = s1_adv;
          slot_wr.we         = s1_adv;
          slot_wr.addr       = q_head.slot;
          slot_wr.data.live  = 1'b1;
          slot_wr.data.gen   = q_head.gen;
          out_idx_nxt        = q_head.slot;
          out_ver_nxt        = hga_pkg::VER_W'(q_head.gen);
        end else if (high_water_r < hga_pkg::CNT_W'(hga_pkg::SLOT_COUNT)) begin
          slot_wr.we         = s1_adv;
          slot_wr.addr       = high_water_r[hga_pkg::IDX_W-1:0];
          slot_wr.data.live  = 1'b1;
          slot_wr.data.gen   = '0;
          high_water_nxt     = high_water_r + 1'b1;
          out_idx_nxt        = high_water_r[hga_pkg::IDX_W-1:0];
        end else begin
          out_status_nxt     = hga_pkg::ST_FULL;
        end
      end
      hga_pkg::OP_DESPAWN: begin
        if (in_range && slot_rd.live && !q_stat.full) begin
          slot_wr.we         = s1_adv;
          slot_wr.addr       = s1_idx_r;
          slot_wr.data.live  = 1'b0;
          slot_wr.data.gen   = gen_bump;
          q_ctl.push         = s1_adv;
          q_ctl.entry.slot   = s1_idx_r;
          q_ctl.entry.gen    = gen_bump;
        end else begin
          out_status_nxt     = hga_pkg::ST_DEAD;
        end
      end
      hga_pkg::OP_QUERY: begin
        out_live_nxt = in_range && slot_rd.live &&
                       (hga_pkg::VER_W'(slot_rd.gen) == s1_ver_r);
      end
      default: begin
      end
    endcase
  end

  // Commit the high-water mark as the word leaves the stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_water_r <= '0;
    end else if (s1_adv) begin
      high_water_r <= high_water_nxt;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_status_r <= out_status_nxt;
      out_idx_r    <= out_idx_nxt;
      out_ver_r    <= out_ver_nxt;
      out_live_r   <= out_live_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {(hga_pkg::OUT_TDATA_W - hga_pkg::IDX_W - hga_pkg::VER_W - 1)'(0),
                       out_live_r, out_ver_r, out_idx_r};

endmodule

`default_nettype wire
